// ===== rtl/core/rsas_pkg.sv =====
`default_nettype none
package rsas_pkg;

    localparam int CNT_W  = 11;   // element count register
    localparam int ADDR_W = 10;   // write address field
    localparam int VAL_W  = 32;   // element / key width
    localparam int POS_W  = 10;   // result position field

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // finished search, held by the sequencer until the output stage takes it
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [POS_W-1:0] position;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/core/rsas_ram.sv =====
`default_nettype none
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/rsas_seq.sv =====
`default_nettype none
module rsas_seq
    import rsas_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [VAL_W-1:0]          i_key,
    input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0] i_n,
    input  wire logic                             i_take,
    output logic                                  o_busy,
    output t_res                                  o_res,
    output logic [$clog2(MAX_ELEMENTS)-1:0]       o_raddr,
    input  wire logic [VAL_W-1:0]                 i_rdata
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LAST = 3'd1;
    localparam logic [2:0] S_MIN  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_BIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]              r_state, n_state;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic signed [VAL_W-1:0] r_vhi, n_vhi;
    logic signed [VAL_W-1:0] r_vlast, n_vlast;
    logic [CW-1:0]           r_n, n_n;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_mid, n_mid;
    logic                    r_found, n_found;
    logic [POS_W-1:0]        r_pos, n_pos;

    logic signed [VAL_W-1:0] rd;
    logic [CW:0]             sum;
    logic [CW-1:0]           mid_next;
    logic [CW-1:0]           n_minus1;

    assign rd       = $signed(i_rdata);
    assign sum      = {1'b0, n_lo} + {1'b0, n_hi};
    assign mid_next = sum[CW:1];

    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_vhi    = r_vhi;
        n_vlast  = r_vlast;
        n_n      = r_n;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_found  = r_found;
        n_pos    = r_pos;
        n_minus1 = i_n - CW'(1);
        o_raddr  = mid_next[AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_raddr = n_minus1[AW-1:0];
                if (i_start) begin
                    n_key   = i_key;
                    n_n     = i_n;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_vlast = rd;
                n_vhi   = rd;
                n_lo    = '0;
                n_hi    = r_n - CW'(1);
                n_mid   = mid_next;
                n_state = (n_lo < n_hi) ? S_MIN : S_DEC;
            end
            S_MIN: begin
                if (rd > r_vhi) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi  = r_mid;
                    n_vhi = rd;
                end
                n_mid   = mid_next;
                n_state = (n_lo < n_hi) ? S_MIN : S_DEC;
            end
            S_DEC: begin
                // r_lo is the rotation point, r_vhi its element
                if (r_key >= r_vhi && r_key <= r_vlast) begin
                    n_lo = r_lo;
                    n_hi = r_n;
                end else begin
                    n_lo = '0;
                    n_hi = r_lo;
                end
                n_mid   = mid_next;
                n_found = 1'b0;
                n_pos   = '0;
                n_state = (n_lo < n_hi) ? S_BIN : S_DONE;
            end
            S_BIN: begin
                if (rd == r_key) begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_mid);
                    n_state = S_DONE;
                end else begin
                    if (rd > r_key) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid + CW'(1);
                    end
                    n_mid   = mid_next;
                    n_state = (n_lo < n_hi) ? S_BIN : S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_key   <= n_key;
        r_vhi   <= n_vhi;
        r_vlast <= n_vlast;
        r_n     <= n_n;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_res.valid    = (r_state == S_DONE);
    assign o_res.found    = r_found;
    assign o_res.position = r_pos;

`ifndef SYNTHESIS
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !i_take) |=> o_res.valid)
        else $error("finished search dropped before it was taken");
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIN || r_state == S_BIN) |->
        (r_lo <= r_mid && r_mid < r_hi && r_hi <= r_n))
        else $error("probe outside search window");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("search started while busy");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |-> (o_res.position == '0))
        else $error("miss with nonzero position");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/rotated_sorted_array_search.sv =====
// channel   | handshake                   | payload
// ----------+-----------------------------+-------------------------------
// config    | i_cfg_wr_en                 | i_cfg_wr_data (element count)
// input     | i_in_valid / o_in_stall     | i_command, i_address, i_value
// output    | o_out_valid / i_out_stall   | o_found, o_position
//
// a write transaction is accepted while idle and leaves the sequencer idle
// a search finds the rotation point, picks the half that holds the key and
//   searches it: one probe per cycle on the single ram read port
// the input is stalled while a search runs, so ram reads never meet a write
// a finished result waits in the sequencer while the output register is stalled;
//   the next transaction is accepted as soon as the sequencer is idle
// reset (synchronous, active low) sets the count to 1; the store is not cleared
`default_nettype none
module rotated_sorted_array_search
    import rsas_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CNT_W-1:0]        i_cfg_wr_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_command,
    input  wire logic [ADDR_W-1:0]       i_address,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic                         o_found,
    output logic [POS_W-1:0]             o_position
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic [CNT_W-1:0] r_count;
    logic [CW-1:0]    use_n;
    logic             busy;
    logic             in_acc;
    logic             wr_en;
    logic             start;
    logic             take;
    t_res             res;
    logic [AW-1:0]    raddr;
    logic [VAL_W-1:0] rdata;
    logic             r_out_valid;
    logic             r_found;
    logic [POS_W-1:0] r_pos;

    // element count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            r_count <= i_cfg_wr_data;
        end
    end

    // count in use: zero reads as one, saturate at the store depth
    always_comb begin
        if (r_count == '0) begin
            use_n = CW'(1);
        end else if (32'(r_count) > 32'(MAX_ELEMENTS)) begin
            use_n = CW'(MAX_ELEMENTS);
        end else begin
            use_n = CW'(r_count);
        end
    end

    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !busy;
    // writes past the store are dropped
    assign wr_en      = in_acc && (i_command == CMD_WRITE)
                        && (32'(i_address) < 32'(MAX_ELEMENTS));
    assign start      = in_acc && (i_command == CMD_SEARCH);

    rsas_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_address)),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // pivot search, half choice and key search over the store
    rsas_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_key   (i_value),
        .i_n     (use_n),
        .i_take  (take),
        .o_busy  (busy),
        .o_res   (res),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // output register: loads when empty or draining this cycle
    assign take = res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_found <= res.found;
            r_pos   <= res.position;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_pos;

endmodule
`default_nettype wire
